// ===== rtl/core/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// leb_pkg: shared definitions of the line edit buffer
// Sizes, key codes, register indexes and the command and status types that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int COUNT_W       = 7;
  localparam int CHAR_W        = 8;
  localparam int REG_IDX_W     = 2;

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(LINE_CAPACITY);

  localparam logic [CHAR_W-1:0] KEY_RIGHT_CODE = 8'd29;
  localparam logic [CHAR_W-1:0] KEY_LEFT_CODE  = 8'd157;
  localparam logic [CHAR_W-1:0] PRINT_LOW      = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HIGH     = 8'd126;

  localparam logic [REG_IDX_W-1:0] REG_LINE_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTER      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BACKSPACE  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DELETE     = 2'd3;

  localparam logic [COUNT_W-1:0] RST_LINE_LIMIT = 7'd63;
  localparam logic [CHAR_W-1:0]  RST_ENTER      = 8'd13;
  localparam logic [CHAR_W-1:0]  RST_BACKSPACE  = 8'd20;
  localparam logic [CHAR_W-1:0]  RST_DELETE     = 8'd127;

  // Action that a key code calls for, given the present line.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_EMPTY,
    ACT_INSERT,
    ACT_ERASE,
    ACT_RIGHT,
    ACT_LEFT
  } act_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INS_START,
    OP_INS_STEP,
    OP_INS_KEY,
    OP_DEL_START,
    OP_DEL_STEP,
    OP_EMIT_START,
    OP_EMIT_STEP,
    OP_EMPTY,
    OP_RIGHT,
    OP_LEFT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic ins_done;
    logic fwd_done;
  } sts_t;

  typedef struct packed {
    logic [COUNT_W-1:0] line_limit;
    logic [CHAR_W-1:0]  enter_code;
    logic [CHAR_W-1:0]  backspace_code;
    logic [CHAR_W-1:0]  delete_code;
  } cfg_t;

endpackage

// ===== rtl/core/line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// line_edit_buffer: line editor with a cursor
// Keeps a line of up to 64 characters edited by key codes and emits the
// finished line one character per result on the enter code.
// ----------------------------------------------------------------------------
// A key code is taken when start is high and busy is low. Results leave on
// result_valid_o, one per cycle, and cannot be held off: the receiver must
// take each transfer in the cycle it is shown. Timing follows from the line
// store, which has one write and one registered read port and moves one
// character a cycle. Cursor moves, ignored codes and an enter on an empty
// line leave busy low; the empty line gives its single result in the cycle
// after the transfer. An insertion keeps busy high while the characters
// from the cursor on move up one place and the key is written, an erase
// while the characters behind the erased one move down one place. An enter
// on a non-empty line keeps busy high while its characters are shown in
// order after the transfer, the final one marked by last_o.
// Configuration lives behind an APB-style port at byte addresses 0, 4, 8
// and 12 (line limit, enter, backspace and delete codes); pready is always
// high, and writes are meant to be made only while the block is idle.
// ----------------------------------------------------------------------------
module line_edit_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [leb_pkg::CHAR_W-1:0]    key_code_i,
  // Result channel
  output logic                          result_valid_o,
  output logic [leb_pkg::CHAR_W-1:0]    line_char_o,
  output logic                          char_valid_o,
  output logic [leb_pkg::COUNT_W-1:0]   total_length_o,
  output logic                          last_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import leb_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;
  logic start_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes: the register index is the word address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_limit     <= RST_LINE_LIMIT;
      cfg_q.enter_code     <= RST_ENTER;
      cfg_q.backspace_code <= RST_BACKSPACE;
      cfg_q.delete_code    <= RST_DELETE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LINE_LIMIT: cfg_q.line_limit     <= pwdata[COUNT_W-1:0];
        REG_ENTER:      cfg_q.enter_code     <= pwdata[CHAR_W-1:0];
        REG_BACKSPACE:  cfg_q.backspace_code <= pwdata[CHAR_W-1:0];
        REG_DELETE:     cfg_q.delete_code    <= pwdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the register that the word address selects.
  always_comb begin
    case (paddr[3:2])
      REG_LINE_LIMIT: prdata = {25'd0, cfg_q.line_limit};
      REG_ENTER:      prdata = {24'd0, cfg_q.enter_code};
      REG_BACKSPACE:  prdata = {24'd0, cfg_q.backspace_code};
      REG_DELETE:     prdata = {24'd0, cfg_q.delete_code};
      default:        prdata = '0;
    endcase
  end

  // Start is gated with busy, so the controller sees it only while idle.
  assign start_ok = start && !busy;

  leb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_ok),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  leb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .key_code_i     (key_code_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .line_char_o    (line_char_o),
    .char_valid_o   (char_valid_o),
    .total_length_o (total_length_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/core/leb_ctrl.sv =====
// ----------------------------------------------------------------------------
// leb_ctrl: sequencing controller of the line edit buffer
// Accepts key codes and steps the datapath through shifts and line emission.
// ----------------------------------------------------------------------------
module leb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  leb_pkg::sts_t sts_i,
  output leb_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import leb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_KEY,
    ST_DEL_SHIFT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (sts_i.act)
            ACT_INSERT: begin
              cmd_o.op = OP_INS_START;
              state_d  = ST_INS_SHIFT;
            end
            ACT_ERASE: begin
              cmd_o.op = OP_DEL_START;
              state_d  = ST_DEL_SHIFT;
            end
            ACT_EMIT: begin
              cmd_o.op = OP_EMIT_START;
              state_d  = ST_EMIT;
            end
            ACT_EMPTY: cmd_o.op = OP_EMPTY;
            ACT_RIGHT: cmd_o.op = OP_RIGHT;
            ACT_LEFT:  cmd_o.op = OP_LEFT;
            default:   cmd_o.op = OP_NONE;
          endcase
        end
      end
      ST_INS_SHIFT: begin
        cmd_o.op = OP_INS_STEP;
        if (sts_i.ins_done) state_d = ST_INS_KEY;
      end
      ST_INS_KEY: begin
        cmd_o.op = OP_INS_KEY;
        state_d  = ST_IDLE;
      end
      ST_DEL_SHIFT: begin
        cmd_o.op = OP_DEL_STEP;
        if (sts_i.fwd_done) state_d = ST_IDLE;
      end
      ST_EMIT: begin
        cmd_o.op = OP_EMIT_STEP;
        if (sts_i.fwd_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/leb_datapath.sv =====
// ----------------------------------------------------------------------------
// leb_datapath: line store, cursor and count of the line edit buffer
// Decodes key codes, shifts the store one entry a cycle and emits results.
// ----------------------------------------------------------------------------
module leb_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  leb_pkg::cfg_t                 cfg_i,
  input  logic [leb_pkg::CHAR_W-1:0]    key_code_i,
  input  leb_pkg::cmd_t                 cmd_i,
  output leb_pkg::sts_t                 sts_o,
  output logic                          result_valid_o,
  output logic [leb_pkg::CHAR_W-1:0]    line_char_o,
  output logic                          char_valid_o,
  output logic [leb_pkg::COUNT_W-1:0]   total_length_o,
  output logic                          last_o
);
  import leb_pkg::*;

  logic [CHAR_W-1:0]  mem [LINE_CAPACITY];

  logic [COUNT_W-1:0] cursor_q, cursor_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic               wr_pend_q, wr_pend_d;
  logic               out_valid_q, out_valid_d;
  logic               out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic [ADDR_W-1:0]  wr_addr_q, wr_addr_d;
  logic [CHAR_W-1:0]  key_q;
  logic [CHAR_W-1:0]  rd_data_q;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CHAR_W-1:0]  wr_data;
  logic [COUNT_W-1:0] eff_limit;
  logic               ins_more;
  logic               fwd_more;
  act_e               dec_act;

  assign eff_limit = (cfg_i.line_limit < CAP_COUNT) ? cfg_i.line_limit : CAP_COUNT;
  assign ins_more  = (idx_q > cursor_q);
  assign fwd_more  = (idx_q < count_q);

  // Key decode in priority order: enter, erase, right, left, printable.
  always_comb begin
    dec_act = ACT_NONE;
    if (key_code_i == cfg_i.enter_code) begin
      dec_act = (count_q == '0) ? ACT_EMPTY : ACT_EMIT;
    end else if (key_code_i == cfg_i.backspace_code || key_code_i == cfg_i.delete_code) begin
      if (cursor_q != '0) dec_act = ACT_ERASE;
    end else if (key_code_i == KEY_RIGHT_CODE) begin
      if (cursor_q < count_q) dec_act = ACT_RIGHT;
    end else if (key_code_i == KEY_LEFT_CODE) begin
      if (cursor_q != '0) dec_act = ACT_LEFT;
    end else if (key_code_i inside {[PRINT_LOW:PRINT_HIGH]}) begin
      if (count_q < eff_limit) dec_act = ACT_INSERT;
    end
  end

  assign sts_o = '{act: dec_act, ins_done: !ins_more, fwd_done: !fwd_more};

  always_comb begin
    cursor_d    = cursor_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    out_valid_d = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[ADDR_W-1:0];
    case (cmd_i.op)
      OP_INS_START: idx_d = count_q;
      OP_INS_STEP: begin
        if (ins_more) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(idx_q - 7'd1);
          wr_pend_d = 1'b1;
          wr_addr_d = idx_q[ADDR_W-1:0];
          idx_d     = idx_q - 7'd1;
        end
      end
      OP_INS_KEY: begin
        cursor_d = cursor_q + 7'd1;
        count_d  = count_q + 7'd1;
      end
      OP_DEL_START: begin
        cursor_d = cursor_q - 7'd1;
        count_d  = count_q - 7'd1;
        idx_d    = cursor_q - 7'd1;
      end
      OP_DEL_STEP: begin
        if (fwd_more) begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(idx_q + 7'd1);
          wr_pend_d = 1'b1;
          wr_addr_d = idx_q[ADDR_W-1:0];
          idx_d     = idx_q + 7'd1;
        end
      end
      OP_EMIT_START: idx_d = '0;
      OP_EMIT_STEP: begin
        if (fwd_more) begin
          rd_en       = 1'b1;
          out_valid_d = 1'b1;
          out_char_d  = 1'b1;
          out_last_d  = ((idx_q + 7'd1) == count_q);
          idx_d       = idx_q + 7'd1;
        end else begin
          // The final character is on the ports in this cycle.
          cursor_d = '0;
          count_d  = '0;
        end
      end
      OP_EMPTY: begin
        out_valid_d = 1'b1;
        out_char_d  = 1'b0;
        out_last_d  = 1'b1;
      end
      OP_RIGHT: cursor_d = cursor_q + 7'd1;
      OP_LEFT:  cursor_d = cursor_q - 7'd1;
      default: ;
    endcase
  end

  // The key write never meets a pending shift write: the shift has drained.
  assign wr_en   = wr_pend_q || (cmd_i.op == OP_INS_KEY);
  assign wr_addr = (cmd_i.op == OP_INS_KEY) ? cursor_q[ADDR_W-1:0] : wr_addr_q;
  assign wr_data = (cmd_i.op == OP_INS_KEY) ? key_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (cmd_i.op == OP_INS_START) key_q <= key_code_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign line_char_o    = out_char_q ? rd_data_q : '0;
  assign char_valid_o   = out_char_q;
  assign total_length_o = count_q;
  assign last_o         = out_last_q;

endmodule
